// ----- design/vfcm_pkg.sv -----
// Shared constants, types and lookup functions for the voxel face-cull mesher.
`timescale 1ns / 1ps
package vfcm_pkg;

  // Chunk and palette geometry
  localparam int MAX_EDGE      = 32;
  localparam int PALETTE_DEPTH = 256;
  localparam int EW            = $clog2(MAX_EDGE);
  localparam int POS_W         = 5;
  localparam int CW            = ((EW > POS_W) ? EW : POS_W) + 2;
  localparam int VOX_AW        = 3 * EW;
  localparam int VOX_DEPTH     = 1 << VOX_AW;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  // Field widths
  localparam int EDGE_W  = 6;
  localparam int SLOT_W  = 8;
  localparam int VOXEL_W = SLOT_W + 1;
  localparam int RGB_W   = 24;
  localparam int COORD_W = 6;
  localparam int VNUM_W  = 18;
  localparam int CNT_W   = 19;

  // Configuration port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_CHUNK_EDGE = 1'b0;
  localparam logic [EDGE_W-1:0] CHUNK_EDGE_RESET = 6'd32;

  // Command codes
  localparam logic [1:0] CMD_WRITE_VOXEL   = 2'd0;
  localparam logic [1:0] CMD_WRITE_PALETTE = 2'd1;
  localparam logic [1:0] CMD_MESH          = 2'd2;
  localparam logic [1:0] CMD_RESTART       = 2'd3;

  // Result kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } offs_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } coord_t;

  // Corner offsets of the unit cube
  localparam logic CORNER_DX [8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam logic CORNER_DY [8] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
  localparam logic CORNER_DZ [8] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  // Corner slots of each face: bottom, top, front, back, right, left
  localparam logic [2:0] FACE_CORNERS [6][6] = '{
    '{3'd0, 3'd1, 3'd3, 3'd1, 3'd2, 3'd3},
    '{3'd7, 3'd5, 3'd4, 3'd7, 3'd6, 3'd5},
    '{3'd4, 3'd1, 3'd0, 3'd4, 3'd5, 3'd1},
    '{3'd3, 3'd2, 3'd7, 3'd2, 3'd6, 3'd7},
    '{3'd5, 3'd2, 3'd1, 3'd5, 3'd6, 3'd2},
    '{3'd0, 3'd3, 3'd4, 3'd3, 3'd7, 3'd4}
  };

  // Neighbor direction of a face
  function automatic offs_t face_offs(logic [2:0] f);
    offs_t o;
    o = '0;
    unique case (f)
      3'd0:    o.dy = 2'sb11;
      3'd1:    o.dy = 2'sb01;
      3'd2:    o.dz = 2'sb11;
      3'd3:    o.dz = 2'sb01;
      3'd4:    o.dx = 2'sb01;
      3'd5:    o.dx = 2'sb11;
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic offs_t corner_offs(logic [2:0] c);
    offs_t o;
    o.dx = {1'b0, CORNER_DX[c]};
    o.dy = {1'b0, CORNER_DY[c]};
    o.dz = {1'b0, CORNER_DZ[c]};
    return o;
  endfunction

  // Lowest pending face of a six-bit mask
  function automatic logic [2:0] lowest_face(logic [5:0] mask);
    logic [2:0] f;
    f = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (mask[i]) f = 3'(i);
    end
    return f;
  endfunction

  function automatic logic slot_ok(logic [SLOT_W-1:0] s);
    return int'(s) < PALETTE_DEPTH;
  endfunction

endpackage

// ----- design/vfcm_channels.sv -----
// Command and result channel interfaces of the voxel face-cull mesher.
`timescale 1ns / 1ps
interface vfcm_cmd_if import vfcm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [POS_W-1:0]  pos_z;
  logic              air_flag;
  logic [SLOT_W-1:0] palette_slot;
  logic [RGB_W-1:0]  rgb_in;

  modport source (output valid, command, pos_x, pos_y, pos_z, air_flag, palette_slot,
                  rgb_in, input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, air_flag, palette_slot,
                rgb_in, output ready);
endinterface

interface vfcm_res_if import vfcm_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] vert_x;
  logic [COORD_W-1:0] vert_y;
  logic [COORD_W-1:0] vert_z;
  logic [RGB_W-1:0]   rgb_out;
  logic [VNUM_W-1:0]  vertex_number;
  logic               last;

  modport source (output valid, kind, vert_x, vert_y, vert_z, rgb_out, vertex_number, last,
                  input ready);
  modport sink (input valid, kind, vert_x, vert_y, vert_z, rgb_out, vertex_number, last,
                output ready);
endinterface

// ----- design/vfcm_coord_unit.sv -----
// Shared coordinate adder and chunk bounds check for neighbor and corner positions.
`timescale 1ns / 1ps
module vfcm_coord_unit import vfcm_pkg::*; (
  input  pos_t              base,
  input  offs_t             offs,
  input  logic [EDGE_W-1:0] chunk_edge,
  output coord_t            sum,
  output logic              in_bounds
);

  logic signed [CW-1:0] edge_c;

  // Clamp the edge to the store size
  assign edge_c = (int'(chunk_edge) > MAX_EDGE) ? CW'(MAX_EDGE) : CW'(chunk_edge);

  // Add the signed offset on each axis
  assign sum.x = signed'({{(CW-POS_W){1'b0}}, base.x}) + signed'({{(CW-2){offs.dx[1]}}, offs.dx});
  assign sum.y = signed'({{(CW-POS_W){1'b0}}, base.y}) + signed'({{(CW-2){offs.dy[1]}}, offs.dy});
  assign sum.z = signed'({{(CW-POS_W){1'b0}}, base.z}) + signed'({{(CW-2){offs.dz[1]}}, offs.dz});

  assign in_bounds = (sum.x >= 0) && (sum.x < edge_c) &&
                     (sum.y >= 0) && (sum.y < edge_c) &&
                     (sum.z >= 0) && (sum.z < edge_c);

endmodule

// ----- design/voxel_face_cull_mesher.sv -----
// Top level of the voxel face-cull mesher: stores, sequencer, result register, APB port.
`timescale 1ns / 1ps
// Voxel write, palette write and counter restart commands transfer without a stall and
// cmd.ready stays high for them. A mesh command of a voxel inside the chunk drops
// cmd.ready while it reads through the single voxel memory port (the voxel itself, then
// its six neighbors, one address a cycle) and then emits up to 44 results, one a cycle,
// held longer while result.ready is low; an air voxel or a voxel with no exposed face
// ends after the reads with no result. The next command transfers while the final
// result still waits in the output register. The shared coordinate unit forms every
// neighbor address and every vertex position.
module voxel_face_cull_mesher import vfcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  vfcm_cmd_if.sink           cmd,
  vfcm_res_if.source         result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state;
  logic [EDGE_W-1:0]   chunk_edge;
  pos_t                pos_q;
  logic [2:0]          rd_step;
  logic [VOXEL_W-1:0]  center_q;
  logic                nb_in_q;
  logic [5:0]          exposed;
  logic [5:0]          rem;
  logic [2:0]          slot;
  logic [7:0]          seen;
  logic [VNUM_W-1:0]   corner_num [8];
  logic [CNT_W-1:0]    vertex_counter;

  logic [VOXEL_W-1:0]  vox_mem [VOX_DEPTH];
  logic [RGB_W-1:0]    pal_mem [PALETTE_DEPTH];
  logic [VOXEL_W-1:0]  vox_rdata;
  logic [RGB_W-1:0]    pal_rdata;

  logic                res_valid;
  logic                res_kind;
  logic [COORD_W-1:0]  res_x;
  logic [COORD_W-1:0]  res_y;
  logic [COORD_W-1:0]  res_z;
  logic [RGB_W-1:0]    res_rgb;
  logic [VNUM_W-1:0]   res_vnum;
  logic                res_last;

  pos_t                unit_base;
  offs_t               unit_offs;
  coord_t              unit_sum;
  logic                unit_inside;
  logic [VOX_AW-1:0]   vox_addr;

  logic                cmd_xfer;
  logic                cfg_write;
  logic [2:0]          cur_face;
  logic [2:0]          cur_corner;
  logic                is_new;
  logic [5:0]          rem_after;
  logic                emit_last;
  logic                out_load;
  logic                face_exposed;
  logic [5:0]          mask_full;
  logic [RGB_W-1:0]    color;

  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE) && !rst;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2 +: REG_IDX_W] == REG_CHUNK_EDGE) ? APB_DW'(chunk_edge) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_edge <= CHUNK_EDGE_RESET;
    end else if (cfg_write && paddr[2 +: REG_IDX_W] == REG_CHUNK_EDGE) begin
      chunk_edge <= pwdata[EDGE_W-1:0];
    end
  end

  // Emit-side decode
  assign cur_face   = lowest_face(rem);
  assign cur_corner = FACE_CORNERS[cur_face][slot];
  assign is_new     = !seen[cur_corner];
  assign rem_after  = rem & ~(6'b1 << cur_face);
  assign emit_last  = !is_new && (slot == 3'd5) && (rem_after == '0);
  assign out_load   = (state == ST_EMIT) && (!res_valid || result.ready);
  assign color      = slot_ok(center_q[SLOT_W-1:0]) ? pal_rdata : '0;

  // Read-side exposure of the face whose neighbor arrives this cycle
  assign face_exposed = !nb_in_q || vox_rdata[SLOT_W];
  assign mask_full    = {face_exposed, exposed[4:0]};

  // Select the operands of the shared coordinate unit
  always_comb begin
    unit_base = pos_q;
    unit_offs = '0;
    unique case (state)
      ST_IDLE: begin
        unit_base = '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z};
      end
      ST_READ: begin
        if (rd_step != 3'd0) unit_offs = face_offs(3'(rd_step - 3'd1));
      end
      ST_EMIT: begin
        unit_offs = corner_offs(cur_corner);
      end
      default: unit_offs = '0;
    endcase
  end

  vfcm_coord_unit u_coord (
    .base       (unit_base),
    .offs       (unit_offs),
    .chunk_edge (chunk_edge),
    .sum        (unit_sum),
    .in_bounds  (unit_inside)
  );

  assign vox_addr = {unit_sum.x[EW-1:0], unit_sum.y[EW-1:0], unit_sum.z[EW-1:0]};

  // Voxel store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd_xfer && cmd.command == CMD_WRITE_VOXEL && unit_inside) begin
      vox_mem[vox_addr] <= {cmd.air_flag, cmd.palette_slot};
    end
    vox_rdata <= vox_mem[vox_addr];
  end

  // Palette store: one write, one registered read at the meshed voxel's slot
  always_ff @(posedge clk) begin
    if (cmd_xfer && cmd.command == CMD_WRITE_PALETTE && slot_ok(cmd.palette_slot)) begin
      pal_mem[PAL_AW'(cmd.palette_slot)] <= cmd.rgb_in;
    end
    pal_rdata <= pal_mem[PAL_AW'(center_q[SLOT_W-1:0])];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      rd_step        <= '0;
      rem            <= '0;
      slot           <= '0;
      seen           <= '0;
      vertex_counter <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_xfer) begin
            if (cmd.command == CMD_RESTART) begin
              vertex_counter <= '0;
            end else if (cmd.command == CMD_MESH && unit_inside) begin
              pos_q   <= unit_base;
              rd_step <= '0;
              state   <= ST_READ;
            end
          end
        end
        ST_READ: begin
          nb_in_q <= unit_inside;
          rd_step <= rd_step + 3'd1;
          if (rd_step == 3'd1) center_q <= vox_rdata;
          if (rd_step >= 3'd2) exposed[3'(rd_step - 3'd2)] <= face_exposed;
          if (rd_step == 3'd7) begin
            if (center_q[SLOT_W] || mask_full == '0) begin
              state <= ST_IDLE;
            end else begin
              rem   <= mask_full;
              slot  <= '0;
              seen  <= '0;
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (is_new) begin
              seen[cur_corner]       <= 1'b1;
              corner_num[cur_corner] <= vertex_counter[VNUM_W-1:0];
              vertex_counter         <= vertex_counter + CNT_W'(1);
            end else if (slot == 3'd5) begin
              slot <= '0;
              rem  <= rem_after;
              if (rem_after == '0) state <= ST_IDLE;
            end else begin
              slot <= slot + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register: load one result, hold until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (is_new) begin
        res_kind <= KIND_VERTEX;
        res_x    <= COORD_W'(unsigned'(unit_sum.x));
        res_y    <= COORD_W'(unsigned'(unit_sum.y));
        res_z    <= COORD_W'(unsigned'(unit_sum.z));
        res_rgb  <= color;
        res_vnum <= vertex_counter[VNUM_W-1:0];
        res_last <= 1'b0;
      end else begin
        res_kind <= KIND_INDEX;
        res_x    <= '0;
        res_y    <= '0;
        res_z    <= '0;
        res_rgb  <= '0;
        res_vnum <= corner_num[cur_corner];
        res_last <= emit_last;
      end
    end
  end

  assign result.valid         = res_valid;
  assign result.kind          = res_kind;
  assign result.vert_x        = res_x;
  assign result.vert_y        = res_y;
  assign result.vert_z        = res_z;
  assign result.rgb_out       = res_rgb;
  assign result.vertex_number = res_vnum;
  assign result.last          = res_last;

  // A vertex is always followed by its index, so it never closes a command
  a_vertex_not_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == KIND_VERTEX |-> !result.last)
    else $error("vertex result flagged last");

  // Index results carry no position or color
  a_index_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == KIND_INDEX |->
      result.vert_x == '0 && result.vert_y == '0 && result.vert_z == '0 &&
      result.rgb_out == '0)
    else $error("index result with nonzero payload");

  // Emission only runs while a face is pending
  a_emit_has_face: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> rem != '0)
    else $error("emit state with no pending face");

  // Each new vertex advances the counter by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_load && is_new |=> vertex_counter == CNT_W'($past(vertex_counter) + CNT_W'(1)))
    else $error("vertex counter did not advance");

endmodule

// ----- sim/voxel_face_cull_mesher_tb.sv -----
// Self-checking testbench for the voxel face-cull mesher: predicts every result and compares.
`timescale 1ns / 1ps
module voxel_face_cull_mesher_tb;
  import vfcm_pkg::*;

  // Cycles the block may stay busy after its last result (voxel reads plus margin)
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [APB_AW-1:0] EDGE_ADDR = APB_AW'(4 * int'(REG_CHUNK_EDGE));

  // Neighbor offsets: entry 0 is the voxel itself, then bottom, top, front, back, right, left
  localparam int NB_DX [7] = '{0, 0, 0, 0, 0, 1, -1};
  localparam int NB_DY [7] = '{0, -1, 1, 0, 0, 0, 0};
  localparam int NB_DZ [7] = '{0, 0, 0, -1, 1, 0, 0};

  // Unit cube corner offsets
  localparam int OFS_X [8] = '{0, 1, 1, 0, 0, 1, 1, 0};
  localparam int OFS_Y [8] = '{0, 0, 0, 0, 1, 1, 1, 1};
  localparam int OFS_Z [8] = '{0, 0, 1, 1, 0, 0, 1, 1};

  // Corner slots per face, two triangles each
  localparam int FACE_SLOTS [6][6] = '{
    '{0, 1, 3, 1, 2, 3},
    '{7, 5, 4, 7, 6, 5},
    '{4, 1, 0, 4, 5, 1},
    '{3, 2, 7, 2, 6, 7},
    '{5, 2, 1, 5, 6, 2},
    '{0, 3, 4, 3, 7, 4}
  };

  typedef struct {
    logic [1:0]        op;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic              air;
    logic [SLOT_W-1:0] slot;
    logic [RGB_W-1:0]  rgb;
  } mesh_cmd_t;

  typedef struct {
    logic               kind;
    logic [COORD_W-1:0] vx;
    logic [COORD_W-1:0] vy;
    logic [COORD_W-1:0] vz;
    logic [RGB_W-1:0]   rgb;
    logic [VNUM_W-1:0]  vnum;
    logic               last;
  } mesh_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  vfcm_cmd_if cmd_ch ();
  vfcm_res_if res_ch ();

  voxel_face_cull_mesher dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_ch),
    .result  (res_ch)
  );

  // Mirror of the block state
  logic [VOXEL_W-1:0] voxel_mem [VOX_DEPTH];
  bit                 voxel_known [VOX_DEPTH];
  logic [RGB_W-1:0]   palette_mem [PALETTE_DEPTH];
  bit                 palette_known [PALETTE_DEPTH];
  logic [CNT_W-1:0]   vert_count = '0;
  logic [EDGE_W-1:0]  edge_reg = CHUNK_EDGE_RESET;

  mesh_result_t expected_results [$];
  int error_count  = 0;
  int items_sent   = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int idle_cycles  = 0;

  always #5 clk = ~clk;

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int edge_limit();
    return (edge_reg > MAX_EDGE) ? MAX_EDGE : int'(edge_reg);
  endfunction

  function automatic int voxel_addr(int x, int y, int z);
    return (x * MAX_EDGE + y) * MAX_EDGE + z;
  endfunction

  function automatic bit in_chunk(int x, int y, int z);
    int e;
    e = edge_limit();
    return x >= 0 && y >= 0 && z >= 0 && x < e && y < e && z < e;
  endfunction

  // Work out the vertex and index results of one mesh command
  function automatic void predict_mesh(input mesh_cmd_t c);
    logic [VOXEL_W-1:0] v;
    logic [RGB_W-1:0]   color;
    logic [CNT_W-1:0]   corner_num [8];
    bit [7:0]           seen;
    mesh_result_t       r;
    mesh_result_t       batch [$];
    int                 nx, ny, nz, cn;
    v = voxel_mem[voxel_addr(c.x, c.y, c.z)];
    if (v[SLOT_W]) return;
    color = (int'(v[SLOT_W-1:0]) < PALETTE_DEPTH) ? palette_mem[v[SLOT_W-1:0]] : '0;
    seen = '0;
    for (int f = 0; f < 6; f++) begin
      nx = int'(c.x) + NB_DX[f+1];
      ny = int'(c.y) + NB_DY[f+1];
      nz = int'(c.z) + NB_DZ[f+1];
      // Cull the face against a solid neighbor inside the chunk
      if (in_chunk(nx, ny, nz) && !voxel_mem[voxel_addr(nx, ny, nz)][SLOT_W]) continue;
      for (int i = 0; i < 6; i++) begin
        cn = FACE_SLOTS[f][i];
        if (!seen[cn]) begin
          seen[cn] = 1'b1;
          corner_num[cn] = vert_count;
          r.kind = KIND_VERTEX;
          r.vx   = COORD_W'(int'(c.x) + OFS_X[cn]);
          r.vy   = COORD_W'(int'(c.y) + OFS_Y[cn]);
          r.vz   = COORD_W'(int'(c.z) + OFS_Z[cn]);
          r.rgb  = color;
          r.vnum = vert_count[VNUM_W-1:0];
          r.last = 1'b0;
          batch = {batch, r};
          vert_count = vert_count + 1'b1;
        end
        r.kind = KIND_INDEX;
        r.vx   = '0;
        r.vy   = '0;
        r.vz   = '0;
        r.rgb  = '0;
        r.vnum = corner_num[cn][VNUM_W-1:0];
        r.last = 1'b0;
        batch = {batch, r};
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) expected_results = {expected_results, batch[k]};
  endfunction

  // Update the mirror for one accepted command
  function automatic void predict_command(input mesh_cmd_t c);
    bit in_bounds;
    in_bounds = in_chunk(c.x, c.y, c.z);
    case (c.op)
      CMD_WRITE_VOXEL: begin
        if (in_bounds) begin
          voxel_mem[voxel_addr(c.x, c.y, c.z)]   = {c.air, c.slot};
          voxel_known[voxel_addr(c.x, c.y, c.z)] = 1'b1;
        end
      end
      CMD_WRITE_PALETTE: begin
        if (int'(c.slot) < PALETTE_DEPTH) begin
          palette_mem[c.slot]   = c.rgb;
          palette_known[c.slot] = 1'b1;
        end
      end
      CMD_RESTART: vert_count = '0;
      CMD_MESH: if (in_bounds) predict_mesh(c);
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Drive one command, with random gaps, and hold it until it transfers
  task automatic send_cmd(input mesh_cmd_t c);
    @(negedge clk);
    while (roll(src_idle_pct)) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command      <= c.op;
    cmd_ch.pos_x        <= c.x;
    cmd_ch.pos_y        <= c.y;
    cmd_ch.pos_z        <= c.z;
    cmd_ch.air_flag     <= c.air;
    cmd_ch.palette_slot <= c.slot;
    cmd_ch.rgb_in       <= c.rgb;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_command(c);
    items_sent++;
  endtask

  task automatic send_fields(input logic [1:0] op, input int x, input int y, input int z,
                             input logic air, input logic [SLOT_W-1:0] slot,
                             input logic [RGB_W-1:0] rgb);
    mesh_cmd_t c;
    c.op   = op;
    c.x    = POS_W'(x);
    c.y    = POS_W'(y);
    c.z    = POS_W'(z);
    c.air  = air;
    c.slot = slot;
    c.rgb  = rgb;
    send_cmd(c);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
  endtask

  // Stop sending until every predicted result has arrived
  task automatic hold_until_drained();
    drop_valid();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic wait_block_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the chunk edge, upper data bits random
  task automatic write_chunk_edge(input logic [EDGE_W-1:0] value);
    wait_block_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EDGE_ADDR;
    pwdata  <= {(APB_DW-EDGE_W)'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    edge_reg = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write any voxel or palette entry a mesh of (x, y, z) would read before it is known
  task automatic ready_neighborhood(input int x, input int y, input int z);
    int nx, ny, nz, a;
    if (!in_chunk(x, y, z)) return;
    for (int d = 0; d < 7; d++) begin
      nx = x + NB_DX[d];
      ny = y + NB_DY[d];
      nz = z + NB_DZ[d];
      if (in_chunk(nx, ny, nz) && !voxel_known[voxel_addr(nx, ny, nz)])
        send_fields(CMD_WRITE_VOXEL, nx, ny, nz, roll(d == 0 ? 15 : 40),
                    SLOT_W'($urandom_range(0, 255)), RGB_W'($urandom));
    end
    a = voxel_addr(x, y, z);
    if (!palette_known[voxel_mem[a][SLOT_W-1:0]])
      send_fields(CMD_WRITE_PALETTE, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 31), roll(50), voxel_mem[a][SLOT_W-1:0], RGB_W'($urandom));
  endtask

  task automatic mesh_at(input int x, input int y, input int z);
    ready_neighborhood(x, y, z);
    send_fields(CMD_MESH, x, y, z, roll(50), SLOT_W'($urandom_range(0, 255)),
                RGB_W'($urandom));
  endtask

  task automatic set_idling(input int src, input int snk);
    src_idle_pct = src;
    snk_idle_pct = snk;
  endtask

  // Corners of the chunk, culling, air voxel and counter restart
  task automatic test_directed_corners();
    send_fields(CMD_WRITE_PALETTE, 0, 0, 0, 1'b0, 8'hFF, 24'hFFFFFF);
    send_fields(CMD_WRITE_PALETTE, 31, 31, 31, 1'b1, 8'h00, 24'h000000);
    // Far corner, exposed on every side
    send_fields(CMD_WRITE_VOXEL, 31, 31, 31, 1'b0, 8'hFF, 24'hFFFFFF);
    send_fields(CMD_WRITE_VOXEL, 30, 31, 31, 1'b1, 8'h00, 24'h000000);
    send_fields(CMD_WRITE_VOXEL, 31, 30, 31, 1'b1, 8'h00, 24'h000000);
    send_fields(CMD_WRITE_VOXEL, 31, 31, 30, 1'b1, 8'h00, 24'h000000);
    send_fields(CMD_MESH, 31, 31, 31, 1'b1, 8'h00, 24'hFFFFFF);
    // Origin corner, top hidden by a solid neighbor
    send_fields(CMD_WRITE_VOXEL, 0, 0, 0, 1'b0, 8'h00, 24'hFFFFFF);
    send_fields(CMD_WRITE_VOXEL, 0, 1, 0, 1'b0, 8'hFF, 24'h000000);
    send_fields(CMD_WRITE_VOXEL, 1, 0, 0, 1'b1, 8'h00, 24'h000000);
    send_fields(CMD_WRITE_VOXEL, 0, 0, 1, 1'b1, 8'hFF, 24'h000000);
    send_fields(CMD_MESH, 0, 0, 0, 1'b0, 8'hFF, 24'h000000);
    // Air voxel emits nothing
    send_fields(CMD_MESH, 30, 31, 31, 1'b0, 8'h00, 24'h000000);
    send_fields(CMD_RESTART, 31, 31, 31, 1'b1, 8'hFF, 24'hFFFFFF);
    send_fields(CMD_MESH, 0, 0, 0, 1'b1, 8'h00, 24'hFFFFFF);
  endtask

  // Single-voxel chunk, empty chunk, oversized edge
  task automatic test_edge_register();
    write_chunk_edge(6'd1);
    send_fields(CMD_MESH, 0, 0, 0, 1'b0, 8'h00, 24'h000000);
    send_fields(CMD_MESH, 31, 31, 31, 1'b0, 8'h00, 24'h000000);
    send_fields(CMD_WRITE_VOXEL, 5, 5, 5, 1'b0, 8'hFF, 24'h000000);
    write_chunk_edge(6'd0);
    send_fields(CMD_MESH, 0, 0, 0, 1'b0, 8'h00, 24'h000000);
    write_chunk_edge(6'd63);
    send_fields(CMD_MESH, 31, 31, 31, 1'b0, 8'h00, 24'h000000);
  endtask

  // Host-style walk over a small chunk in x, y, z order
  task automatic test_walk();
    write_chunk_edge(6'd3);
    set_idling(19, 19);
    for (int x = 0; x < 3; x++) begin
      for (int y = 0; y < 3; y++) begin
        for (int z = 0; z < 3; z++) mesh_at(x, y, z);
      end
      if (x == 1) hold_until_drained();
    end
  endtask

  // Mixed commands around a moving cluster so that neighbors are shared
  task automatic test_random_mix(input int src, input int snk, input logic [EDGE_W-1:0] chunk,
                                 input int count);
    int stop_at, e, sel, span;
    int base [3];
    int p [3];
    write_chunk_edge(chunk);
    set_idling(src, snk);
    e = edge_limit();
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if (roll(5)) begin
        foreach (base[k]) base[k] = (e > 4) ? $urandom_range(0, e - 4) : 0;
      end
      foreach (p[k]) begin
        span = (e - base[k] > 4) ? 4 : e - base[k];
        p[k] = (roll(12) || span <= 0) ? $urandom_range(0, 31)
                                       : base[k] + $urandom_range(0, span - 1);
      end
      sel = $urandom_range(0, 99);
      if (sel < 55)
        mesh_at(p[0], p[1], p[2]);
      else if (sel < 75)
        send_fields(CMD_WRITE_VOXEL, p[0], p[1], p[2], roll(40),
                    SLOT_W'($urandom_range(0, 255)), RGB_W'($urandom));
      else if (sel < 85)
        send_fields(CMD_WRITE_PALETTE, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 31), roll(50), SLOT_W'($urandom_range(0, 255)),
                    RGB_W'($urandom));
      else if (sel < 90)
        send_fields(CMD_RESTART, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 31), roll(50), SLOT_W'($urandom_range(0, 255)),
                    RGB_W'($urandom));
      else if (sel < 97)
        mesh_at($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
      else
        hold_until_drained();
    end
  endtask

  // Randomize receiver back-pressure
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= !roll(snk_idle_pct);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    mesh_result_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0h vertex_number %0h", res_ch.kind,
               res_ch.vertex_number);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("kind", want.kind, res_ch.kind);
        compare_field("vert_x", want.vx, res_ch.vert_x);
        compare_field("vert_y", want.vy, res_ch.vert_y);
        compare_field("vert_z", want.vz, res_ch.vert_z);
        compare_field("rgb_out", want.rgb, res_ch.rgb_out);
        compare_field("vertex_number", want.vnum, res_ch.vertex_number);
        compare_field("last", want.last, res_ch.last);
      end
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.command      = CMD_WRITE_VOXEL;
    cmd_ch.pos_x        = '0;
    cmd_ch.pos_y        = '0;
    cmd_ch.pos_z        = '0;
    cmd_ch.air_flag     = 1'b0;
    cmd_ch.palette_slot = '0;
    cmd_ch.rgb_in       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_edge_register();
    test_walk();
    test_random_mix(0, 0, 6'd32, 70);
    test_random_mix(49, 0, 6'd5, 70);
    test_random_mix(0, 49, 6'd63, 70);
    test_random_mix(19, 19, 6'd17, 70);

    wait_block_idle();
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/vfcm_pkg.sv
design/vfcm_channels.sv
design/vfcm_coord_unit.sv
design/voxel_face_cull_mesher.sv
sim/voxel_face_cull_mesher_tb.sv
